// ----- src/one_wire_rom_search_engine_macros.svh -----
// ----------------------------------------------------------------------------
// one_wire_rom_search_engine_macros
// assertion macros shared by the rom search engine
// ----------------------------------------------------------------------------
`ifndef ONE_WIRE_ROM_SEARCH_ENGINE_MACROS_SVH
`define ONE_WIRE_ROM_SEARCH_ENGINE_MACROS_SVH

// same-cycle implication, disabled during reset
`define OWS_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define OWS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/ows_pkg.sv -----
// ----------------------------------------------------------------------------
// ows_pkg
// types and constants of the 1-wire rom search engine
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ows_pkg;

    localparam int unsigned ROM_W       = 64;
    localparam int unsigned IDX_W       = 7;
    localparam int unsigned FAM_W       = 4;
    localparam int unsigned CRC_W       = 8;
    localparam int unsigned S_TDATA_W   = 8;
    localparam int unsigned M_TDATA_W   = 80;

    localparam logic [CRC_W-1:0] CRC_POLY     = 8'h8C;
    localparam logic [IDX_W-1:0] BIT_LIMIT    = 7'd65;
    localparam logic [IDX_W-1:0] FAMILY_LIMIT = 7'd9;
    localparam logic [IDX_W-1:0] LAST_BIT     = 7'd64;
    localparam logic [IDX_W-1:0] FIRST_BIT    = 7'd1;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_PASS  = 2'd1,
        OP_BIT   = 2'd2
    } op_t;

    typedef enum logic [3:0] {
        ST_STARTED     = 4'd0,
        ST_PASS_OPEN   = 4'd1,
        ST_BIT_DECIDED = 4'd2,
        ST_FOUND       = 4'd3,
        ST_NO_PRESENCE = 4'd4,
        ST_NO_RESPONSE = 4'd5,
        ST_CRC_BAD     = 4'd6,
        ST_EXHAUSTED   = 4'd7,
        ST_IGNORED     = 4'd8
    } status_t;

    typedef struct packed {
        logic [1:0] op;
        logic       presence;
        logic       id_bit;
        logic       cmp_bit;
    } item_t;

    typedef struct packed {
        logic [ROM_W-1:0] rom_bits;
        logic [IDX_W-1:0] discrepancy_mark;
        logic [FAM_W-1:0] family_mark;
        logic             final_found;
        logic             pass_active;
        logic [IDX_W-1:0] bit_index;
        logic [IDX_W-1:0] zero_mark;
        logic [CRC_W-1:0] crc_acc;
    } search_state_t;

    typedef struct packed {
        status_t          status;
        logic             write_valid;
        logic             write_bit;
        logic [ROM_W-1:0] rom_code;
        logic             last_device;
        logic [FAM_W-1:0] family_discrepancy;
    } result_t;

    localparam search_state_t STATE_CLEAR = '{
        rom_bits:         '0,
        discrepancy_mark: '0,
        family_mark:      '0,
        final_found:      1'b0,
        pass_active:      1'b0,
        bit_index:        FIRST_BIT,
        zero_mark:        '0,
        crc_acc:          '0
    };

endpackage

// ----- src/ows_in_reg.sv -----
// ----------------------------------------------------------------------------
// ows_in_reg
// input register stage, unpacks the incoming transaction
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ows_in_reg (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // op[1:0], presence[2], id_bit[3], cmp_bit[4], zero fill [7:5]
    input  logic [ows_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                           take,
    output logic                           item_valid,
    output ows_pkg::item_t                 item
);
    import ows_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign s_tready   = !valid_reg || take;
    assign valid_next = (s_tvalid && s_tready) || (valid_reg && !take);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.op       <= s_tdata[1:0];
            item_reg.presence <= s_tdata[2];
            item_reg.id_bit   <= s_tdata[3];
            item_reg.cmp_bit  <= s_tdata[4];
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ----- src/ows_decide.sv -----
// ----------------------------------------------------------------------------
// ows_decide
// search decision logic: next search state and result for one item
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ows_decide (
    input  ows_pkg::item_t         item,
    input  ows_pkg::search_state_t state,
    output ows_pkg::search_state_t state_next,
    output ows_pkg::result_t       result
);
    import ows_pkg::*;

    always_comb begin
        logic [IDX_W-1:0] idx;
        logic [5:0]       pos;
        logic             dir;
        logic             mix;
        logic [IDX_W-1:0] idx_inc;
        logic [CRC_W-1:0] crc_new;
        status_t          status;
        logic             wvalid;
        logic             wbit;

        state_next = state;
        status     = ST_IGNORED;
        wvalid     = 1'b0;
        wbit       = 1'b0;
        idx        = state.bit_index;
        if (idx < FIRST_BIT || idx > LAST_BIT) begin
            idx = FIRST_BIT;
        end
        pos     = idx[5:0] - 6'd1;
        dir     = 1'b0;
        mix     = 1'b0;
        crc_new = '0;
        idx_inc = idx + FIRST_BIT;

        unique case (item.op)
            OP_START: begin
                state_next = STATE_CLEAR;
                status     = ST_STARTED;
            end
            OP_PASS: begin
                if (state.final_found) begin
                    state_next.pass_active = 1'b0;
                    status                 = ST_EXHAUSTED;
                end else if (!item.presence) begin
                    state_next.discrepancy_mark = '0;
                    state_next.family_mark      = '0;
                    state_next.final_found      = 1'b0;
                    state_next.pass_active      = 1'b0;
                    status                      = ST_NO_PRESENCE;
                end else begin
                    state_next.pass_active = 1'b1;
                    state_next.bit_index   = FIRST_BIT;
                    state_next.zero_mark   = '0;
                    state_next.crc_acc     = '0;
                    status                 = ST_PASS_OPEN;
                end
            end
            OP_BIT: begin
                if (state.pass_active) begin
                    if (item.id_bit && item.cmp_bit) begin
                        state_next.pass_active = 1'b0;
                        status                 = ST_NO_RESPONSE;
                    end else begin
                        if (item.id_bit != item.cmp_bit) begin
                            dir = item.id_bit;
                        end else begin
                            if (idx < state.discrepancy_mark) begin
                                dir = state.rom_bits[pos];
                            end else begin
                                dir = (idx == state.discrepancy_mark);
                            end
                            if (!dir) begin
                                state_next.zero_mark = idx;
                                if (idx < FAMILY_LIMIT) begin
                                    state_next.family_mark = idx[FAM_W-1:0];
                                end
                            end
                        end
                        state_next.rom_bits[pos] = dir;
                        mix     = state.crc_acc[0] ^ dir;
                        crc_new = {1'b0, state.crc_acc[CRC_W-1:1]} ^ (mix ? CRC_POLY : '0);
                        state_next.crc_acc   = crc_new;
                        state_next.bit_index = idx_inc;
                        wvalid = 1'b1;
                        wbit   = dir;
                        status = ST_BIT_DECIDED;
                        if (idx_inc >= BIT_LIMIT) begin
                            state_next.pass_active = 1'b0;
                            if (crc_new == '0) begin
                                state_next.discrepancy_mark = state_next.zero_mark;
                                if (state_next.zero_mark == '0) begin
                                    state_next.final_found = 1'b1;
                                end
                                status = ST_FOUND;
                            end else begin
                                status = ST_CRC_BAD;
                            end
                        end
                    end
                end
            end
            default: begin
                status = ST_IGNORED;
            end
        endcase

        result.status             = status;
        result.write_valid        = wvalid;
        result.write_bit          = wbit;
        result.rom_code           = state_next.rom_bits;
        result.last_device        = state_next.final_found;
        result.family_discrepancy = state_next.family_mark;
    end

endmodule

// ----- src/one_wire_rom_search_engine.sv -----
// result path: the input reg holds the transaction, then the result reg holds its result
// throughput: one transaction per cycle unless m_tready stalls the result register
// a stalled result holds the result register while the input register takes one more item
// reset: aresetn synchronous, active low; clears the search state (bit index to one),
// both valid flags; no clearing pass
// ----------------------------------------------------------------------------
// one_wire_rom_search_engine
// decision engine of the 1-wire search rom algorithm, one bit pair per transaction
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "one_wire_rom_search_engine_macros.svh"

module one_wire_rom_search_engine (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // op[1:0], presence[2], id_bit[3], cmp_bit[4], zero fill [7:5]
    input  logic [ows_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // status[3:0], write_valid[4], write_bit[5], rom_code[69:6],
    // last_device[70], family_discrepancy[74:71], zero fill [79:75]
    output logic [ows_pkg::M_TDATA_W-1:0]  m_tdata
);
    import ows_pkg::*;

    logic          item_valid;
    item_t         item;
    logic          take;
    search_state_t state_reg;
    search_state_t state_next;
    result_t       result;
    result_t       out_reg;
    logic          out_valid_reg;
    logic          out_valid_next;

    assign take = item_valid && (!out_valid_reg || m_tready);

    ows_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    ows_decide u_decide (
        .item       (item),
        .state      (state_reg),
        .state_next (state_next),
        .result     (result)
    );

    assign out_valid_next = take || (out_valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= STATE_CLEAR;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (take) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0,
                       out_reg.family_discrepancy,
                       out_reg.last_device,
                       out_reg.rom_code,
                       out_reg.write_bit,
                       out_reg.write_valid,
                       out_reg.status};

    `OWS_ASSERT_NOW(a_wbit_needs_wvalid, aclk, aresetn,
        m_tvalid && out_reg.write_bit, out_reg.write_valid,
        "write_bit set without write_valid")
    `OWS_ASSERT_NOW(a_no_presence_clears, aclk, aresetn,
        m_tvalid && out_reg.status == ST_NO_PRESENCE,
        out_reg.family_discrepancy == '0 && !out_reg.last_device,
        "no presence left marks set")
    `OWS_ASSERT_NOW(a_found_last_device, aclk, aresetn,
        m_tvalid && out_reg.status == ST_FOUND,
        out_reg.last_device == (state_reg.discrepancy_mark == '0),
        "last device flag disagrees with discrepancy")
    `OWS_ASSERT_NEXT(a_pending_item_moves, aclk, aresetn,
        item_valid && !out_valid_reg, out_valid_reg,
        "pending item not moved to result register")

endmodule

// ----- test/ows_search_checker.sv -----
// ----------------------------------------------------------------------------
// ows_search_checker
// watches both channels of the rom search engine, predicts every result
// from its own copy of the search state and compares it field by field
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ows_search_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    // op[1:0], presence[2], id_bit[3], cmp_bit[4], zero fill [7:5]
    input  logic [ows_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    // status[3:0], write_valid[4], write_bit[5], rom_code[69:6],
    // last_device[70], family_discrepancy[74:71], zero fill [79:75]
    input  logic [ows_pkg::M_TDATA_W-1:0] m_tdata,
    output int                            fail_count,
    output int                            pending_count
);

    import ows_pkg::*;

    logic [ROM_W-1:0] rom_image;
    logic [IDX_W-1:0] resume_mark;
    logic [FAM_W-1:0] family_mark;
    logic             search_done;
    logic             pass_open;
    logic [IDX_W-1:0] next_bit;
    logic [IDX_W-1:0] zero_pos;
    logic [CRC_W-1:0] crc_run;

    result_t expected_q[$];

    initial begin
        fail_count    = 0;
        pending_count = 0;
    end

    task automatic clear_search_state();
        rom_image   = '0;
        resume_mark = '0;
        family_mark = '0;
        search_done = 1'b0;
        pass_open   = 1'b0;
        next_bit    = FIRST_BIT;
        zero_pos    = '0;
        crc_run     = '0;
    endtask

    task automatic decide_search_item(input logic [1:0] op, input logic presence,
                                      input logic id_bit, input logic cmp_bit,
                                      output result_t r);
        logic [IDX_W-1:0] idx;
        logic             dir;
        logic             mix;
        r.status      = ST_IGNORED;
        r.write_valid = 1'b0;
        r.write_bit   = 1'b0;
        case (op)
            OP_START: begin
                clear_search_state();
                r.status = ST_STARTED;
            end
            OP_PASS: begin
                if (search_done) begin
                    pass_open = 1'b0;
                    r.status  = ST_EXHAUSTED;
                end else if (!presence) begin
                    resume_mark = '0;
                    family_mark = '0;
                    pass_open   = 1'b0;
                    r.status    = ST_NO_PRESENCE;
                end else begin
                    pass_open = 1'b1;
                    next_bit  = FIRST_BIT;
                    zero_pos  = '0;
                    crc_run   = '0;
                    r.status  = ST_PASS_OPEN;
                end
            end
            OP_BIT: begin
                if (pass_open && id_bit && cmp_bit) begin
                    pass_open = 1'b0;
                    r.status  = ST_NO_RESPONSE;
                end else if (pass_open) begin
                    idx = next_bit;
                    if (idx < FIRST_BIT || idx > LAST_BIT)
                        idx = FIRST_BIT;
                    if (id_bit != cmp_bit) begin
                        dir = id_bit;
                    end else begin
                        if (idx < resume_mark)
                            dir = rom_image[idx - 1];
                        else
                            dir = (idx == resume_mark);
                        if (!dir) begin
                            zero_pos = idx;
                            if (idx < FAMILY_LIMIT)
                                family_mark = idx[FAM_W-1:0];
                        end
                    end
                    rom_image[idx - 1] = dir;
                    mix     = crc_run[0] ^ dir;
                    crc_run = crc_run >> 1;
                    if (mix)
                        crc_run = crc_run ^ CRC_POLY;
                    r.write_valid = 1'b1;
                    r.write_bit   = dir;
                    next_bit      = idx + 1'b1;
                    r.status      = ST_BIT_DECIDED;
                    if (next_bit >= BIT_LIMIT) begin
                        pass_open = 1'b0;
                        if (crc_run == '0) begin
                            resume_mark = zero_pos;
                            if (resume_mark == '0)
                                search_done = 1'b1;
                            r.status = ST_FOUND;
                        end else begin
                            r.status = ST_CRC_BAD;
                        end
                    end
                end
            end
            default: ;
        endcase
        r.rom_code           = rom_image;
        r.last_device        = search_done;
        r.family_discrepancy = family_mark;
    endtask

    task automatic check_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $display("%0t checker: %s expected %h actual %h", $time, field, want, got);
            fail_count = fail_count + 1;
        end
    endtask

    always @(posedge aclk) begin
        result_t want;
        result_t predicted;
        if (!aresetn) begin
            clear_search_state();
            expected_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_q.size() == 0) begin
                    $display("%0t checker: result expected none actual %h", $time, m_tdata);
                    fail_count = fail_count + 1;
                end else begin
                    want = expected_q.pop_front();
                    check_field("status", 64'(want.status), 64'(m_tdata[3:0]));
                    check_field("write_valid", 64'(want.write_valid), 64'(m_tdata[4]));
                    check_field("write_bit", 64'(want.write_bit), 64'(m_tdata[5]));
                    check_field("rom_code", want.rom_code, m_tdata[69:6]);
                    check_field("last_device", 64'(want.last_device), 64'(m_tdata[70]));
                    check_field("family_discrepancy", 64'(want.family_discrepancy),
                                64'(m_tdata[74:71]));
                end
            end
            if (s_tvalid && s_tready) begin
                decide_search_item(s_tdata[1:0], s_tdata[2], s_tdata[3], s_tdata[4],
                                   predicted);
                expected_q.push_back(predicted);
            end
        end
        pending_count = expected_q.size();
    end

endmodule

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// stimulus for the rom search engine: short directed checks of every op and
// corner, then full searches over random device sets on a modeled wired-and
// bus, mixed with broken passes and noise, under bursty input and stalls
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    import ows_pkg::*;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         ITEM_TARGET = 1000;
    localparam int         MAX_DEV     = 4;

    localparam int RX_FREE   = 0;
    localparam int RX_COIN   = 1;
    localparam int RX_HOLD   = 2;
    localparam int RX_SPARSE = 3;

    logic                  aclk;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;

    int fail_count;
    int pending_count;
    int burst_left  = 0;
    int items_sent  = 0;
    int rx_mode     = RX_FREE;
    int rx_left     = 0;
    bit drained     = 1'b0;

    logic [ROM_W-1:0] dev_rom [MAX_DEV];

    one_wire_rom_search_engine DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    ows_search_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #2000000;
        $display("tb_top: errors");
        $finish;
    end

    function automatic logic coin();
        return 1'($urandom_range(0, 1));
    endfunction

    // receiver stall pattern
    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = $urandom_range(RX_FREE, RX_SPARSE);
            rx_left = $urandom_range(4, 40);
        end
        rx_left = rx_left - 1;
        case (rx_mode)
            RX_FREE:  m_tready <= 1'b1;
            RX_COIN:  m_tready <= coin();
            RX_HOLD:  m_tready <= 1'b0;
            default:  m_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    task automatic send_item(input logic [1:0] op, input logic presence,
                             input logic id_bit, input logic cmp_bit);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            repeat (gap) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, cmp_bit, id_bit, presence, op};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        burst_left = burst_left - 1;
        if (op != OP_UNUSED)
            items_sent = items_sent + 1;
    endtask

    task automatic wait_drained();
        s_tvalid  <= 1'b0;
        burst_left = 0;
        do
            @(posedge aclk);
        while (pending_count != 0);
    endtask

    function automatic logic [CRC_W-1:0] crc_over(input logic [55:0] body);
        logic [CRC_W-1:0] c;
        logic             mix;
        c = '0;
        for (int i = 0; i < 56; i++) begin
            mix = c[0] ^ body[i];
            c   = c >> 1;
            if (mix)
                c = c ^ CRC_POLY;
        end
        return c;
    endfunction

    function automatic logic [ROM_W-1:0] lsb_first(input logic [ROM_W-1:0] v);
        logic [ROM_W-1:0] r;
        for (int i = 0; i < ROM_W; i++)
            r[ROM_W-1-i] = v[i];
        return r;
    endfunction

    // full search over a random device set; devices answer as a wired-and
    // bus, each pass following the device the search reaches next
    task automatic run_search();
        int               n;
        int               k;
        int               passes;
        int               broken_at;
        logic [7:0]       family;
        logic [55:0]      body;
        logic [ROM_W-1:0] swap;
        logic [MAX_DEV-1:0] alive;
        logic             idb;
        logic             cmpb;
        n      = $urandom_range(1, MAX_DEV);
        family = 8'($urandom);
        for (int d = 0; d < n; d++) begin
            body[55:8] = 48'({$urandom, $urandom});
            body[7:0]  = $urandom_range(0, 1) ? family : 8'($urandom);
            dev_rom[d] = {crc_over(body), body};
        end
        if ($urandom_range(0, 7) == 0) begin
            n          = 1;
            dev_rom[0] = {$urandom, $urandom};
        end
        for (int i = 0; i < n; i++)
            for (int j = 0; j + 1 < n - i; j++)
                if (lsb_first(dev_rom[j]) > lsb_first(dev_rom[j + 1])) begin
                    swap           = dev_rom[j];
                    dev_rom[j]     = dev_rom[j + 1];
                    dev_rom[j + 1] = swap;
                end
        send_item(OP_START, coin(), coin(), coin());
        k      = 0;
        passes = 0;
        while (k < n && passes < n + 3) begin
            passes = passes + 1;
            if ($urandom_range(0, 15) == 0) begin
                send_item(OP_PASS, 1'b0, coin(), coin());
                k = 0;
            end
            send_item(OP_PASS, 1'b1, coin(), coin());
            broken_at = ($urandom_range(0, 11) == 0) ? $urandom_range(1, 64) : 0;
            alive = '0;
            for (int d = 0; d < n; d++)
                alive[d] = 1'b1;
            for (int b = 0; b < ROM_W; b++) begin
                idb  = 1'b1;
                cmpb = 1'b1;
                for (int d = 0; d < n; d++)
                    if (alive[d]) begin
                        idb  = idb & dev_rom[d][b];
                        cmpb = cmpb & ~dev_rom[d][b];
                    end
                if (b + 1 == broken_at) begin
                    send_item(OP_BIT, coin(), 1'b1, 1'b1);
                    break;
                end
                send_item(OP_BIT, coin(), idb, cmpb);
                for (int d = 0; d < n; d++)
                    if (dev_rom[d][b] != dev_rom[k][b])
                        alive[d] = 1'b0;
            end
            if (broken_at == 0)
                k = k + 1;
        end
        send_item(OP_PASS, 1'b1, coin(), coin());
    endtask

    task automatic run_short_pass();
        int len;
        int pick;
        send_item(OP_PASS, 1'b1, coin(), coin());
        len = $urandom_range(1, 12);
        repeat (len) begin
            pick = $urandom_range(0, 7);
            case (pick)
                0, 1:    send_item(OP_BIT, coin(), 1'b0, 1'b0);
                2, 3, 4: send_item(OP_BIT, coin(), 1'b0, 1'b1);
                7:       send_item(OP_BIT, coin(), 1'b1, 1'b1);
                default: send_item(OP_BIT, coin(), 1'b1, 1'b0);
            endcase
        end
    endtask

    initial begin
        int pick;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed corners
        send_item(OP_PASS, 1'b0, 1'b0, 1'b0);
        send_item(OP_BIT, 1'b0, 1'b1, 1'b0);
        send_item(OP_UNUSED, 1'b1, 1'b1, 1'b1);
        send_item(OP_START, 1'b1, 1'b1, 1'b1);
        send_item(OP_PASS, 1'b1, 1'b0, 1'b0);
        send_item(OP_PASS, 1'b1, 1'b1, 1'b1);
        send_item(OP_BIT, 1'b0, 1'b0, 1'b1);
        send_item(OP_BIT, 1'b1, 1'b1, 1'b0);
        send_item(OP_BIT, 1'b0, 1'b0, 1'b0);
        send_item(OP_BIT, 1'b1, 1'b0, 1'b0);
        send_item(OP_BIT, 1'b0, 1'b1, 1'b1);
        send_item(OP_BIT, 1'b0, 1'b0, 1'b0);
        send_item(OP_PASS, 1'b0, 1'b1, 1'b1);
        send_item(OP_UNUSED, 1'b0, 1'b0, 1'b0);
        send_item(OP_START, 1'b0, 1'b0, 1'b0);

        while (items_sent < ITEM_TARGET) begin
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
                run_search();
            end else if (pick < 8) begin
                run_short_pass();
            end else begin
                repeat ($urandom_range(1, 5))
                    send_item(2'($urandom_range(0, 3)), coin(), coin(), coin());
            end
            if (!drained && items_sent > ITEM_TARGET / 2) begin
                wait_drained();
                drained = 1'b1;
            end
        end

        wait_drained();
        repeat (8) @(posedge aclk);
        if (fail_count == 0 && pending_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
